### rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants for the ultrasonic echo ranger
// Holds the phase and timer command codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package uer_pkg;

  // Counter widths and limits.
  localparam int US_W       = 17;
  localparam int SUB_W      = 8;
  localparam logic [US_W-1:0] US_MAX = {US_W{1'b1}};

  // Distance conversion: us * 1124 / 65536 approximates us * 0.0343 / 2.
  localparam int FACTOR_W   = 11;
  localparam logic [FACTOR_W-1:0] DIST_FACTOR = 11'd1124;
  localparam int DIST_SHIFT = 16;
  localparam int DIST_WIDTH_DEF = 11;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLES_PER_US = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_US    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_US    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_US     = 2'd3;

  localparam logic [7:0]  CYCLES_PER_US_RST = 8'd16;
  localparam logic [15:0] TIMEOUT_US_RST    = 16'd30000;
  localparam logic [7:0]  TRIGGER_US_RST    = 8'd10;
  localparam logic [7:0]  SETTLE_US_RST     = 8'd2;

  // Measurement phases.
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SETTLE = 3'd1,
    PH_TRIG   = 3'd2,
    PH_RISE   = 3'd3,
    PH_HIGH   = 3'd4
  } phase_t;

  // Commands from the controller to the microsecond timer.
  typedef enum logic [1:0] {
    TMR_HOLD  = 2'd0,
    TMR_CLEAR = 2'd1,
    TMR_TICK  = 2'd2
  } tmr_cmd_t;

  // Configuration register values.
  typedef struct packed {
    logic [7:0]  cycles_per_us;
    logic [15:0] timeout_us;
    logic [7:0]  trigger_us;
    logic [7:0]  settle_us;
  } cfg_t;

  // Single-bit result flags of one tick.
  typedef struct packed {
    logic trig;
    logic busy;
    logic done;
    logic tout;
  } res_flags_t;

endpackage

### rtl/uer_timer.sv
// ----------------------------------------------------------------------------
// uer_timer: prescaled microsecond counter
// Counts clock ticks up to the prescaler reload and then bumps a saturating
// microsecond count. Offers the ticked count ahead of the register update.
// ----------------------------------------------------------------------------
module uer_timer
  import uer_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  tmr_cmd_t        cmd,
  input  logic [7:0]      cycles_per_us,
  output logic [US_W-1:0] us_count,
  output logic [US_W-1:0] us_ticked
);

  logic [SUB_W-1:0] sub_us_count;
  logic [SUB_W-1:0] sub_us_count_next;
  logic [US_W-1:0]  us_count_next;
  logic [SUB_W-1:0] sub_inc;
  logic [SUB_W-1:0] reload;
  logic             wrap;
  logic [SUB_W-1:0] sub_ticked;

  // A prescaler of zero counts as one.
  assign reload     = (cycles_per_us == '0) ? SUB_W'(1) : cycles_per_us;
  assign sub_inc    = sub_us_count + SUB_W'(1);
  assign wrap       = (sub_inc >= reload);
  assign sub_ticked = wrap ? '0 : sub_inc;
  assign us_ticked  = (wrap && (us_count != US_MAX)) ? us_count + US_W'(1) : us_count;

  // Select the next counter values from the controller command.
  always_comb begin
    case (cmd)
      TMR_CLEAR: begin
        sub_us_count_next = '0;
        us_count_next     = '0;
      end
      TMR_TICK: begin
        sub_us_count_next = sub_ticked;
        us_count_next     = us_ticked;
      end
      default: begin
        sub_us_count_next = sub_us_count;
        us_count_next     = us_count;
      end
    endcase
  end

  // Counters advance once per transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      sub_us_count <= '0;
      us_count     <= '0;
    end else if (accept) begin
      sub_us_count <= sub_us_count_next;
      us_count     <= us_count_next;
    end
  end

endmodule

### rtl/uer_dist.sv
// ----------------------------------------------------------------------------
// uer_dist: echo time to distance conversion
// Multiplies the pulse width by the fixed-point sound factor, drops the
// fraction and saturates to the distance width.
// ----------------------------------------------------------------------------
module uer_dist
  import uer_pkg::*;
#(
  parameter int DIST_WIDTH = DIST_WIDTH_DEF
) (
  input  logic [US_W-1:0]       us,
  output logic [DIST_WIDTH-1:0] echo_cm
);

  localparam int PROD_W = US_W + FACTOR_W;
  localparam int DRAW_W = PROD_W - DIST_SHIFT;
  localparam int SAT_W  = ((DIST_WIDTH > DRAW_W) ? DIST_WIDTH : DRAW_W) + 1;
  localparam logic [SAT_W-1:0] LIM = SAT_W'((64'd1 << DIST_WIDTH) - 64'd1);

  logic [PROD_W-1:0] prod;
  logic [SAT_W-1:0]  d_ext;
  logic [SAT_W-1:0]  d_sat;

  // Product, integer part, then clamp.
  assign prod    = PROD_W'(us) * PROD_W'(DIST_FACTOR);
  assign d_ext   = SAT_W'(prod[PROD_W-1:DIST_SHIFT]);
  assign d_sat   = (d_ext > LIM) ? LIM : d_ext;
  assign echo_cm = d_sat[DIST_WIDTH-1:0];

endmodule

### rtl/uer_ctrl.sv
// ----------------------------------------------------------------------------
// uer_ctrl: measurement sequencer
// Walks through settle, trigger, echo rise wait and echo high timing, and
// keeps the last distance. Produces the next-tick result values.
// ----------------------------------------------------------------------------
module uer_ctrl
  import uer_pkg::*;
#(
  parameter int DIST_WIDTH = DIST_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic                  start_req,
  input  logic                  echo_level,
  input  cfg_t                  cfg,
  input  logic [US_W-1:0]       us_ticked,
  input  logic [DIST_WIDTH-1:0] echo_cm,
  output tmr_cmd_t              cmd,
  output res_flags_t            flags,
  output logic [DIST_WIDTH-1:0] distance_next
);

  phase_t                phase;
  phase_t                phase_next;
  logic [DIST_WIDTH-1:0] last_distance;
  logic                  done;
  logic                  tout;
  logic                  echo_fell;

  // Next phase, timer command and end-of-measurement flags.
  always_comb begin
    phase_next = phase;
    cmd        = TMR_HOLD;
    done       = 1'b0;
    tout       = 1'b0;
    echo_fell  = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (start_req) begin
          cmd        = TMR_CLEAR;
          phase_next = (cfg.settle_us == '0) ? PH_TRIG : PH_SETTLE;
        end
      end
      PH_SETTLE: begin
        cmd = TMR_TICK;
        if (us_ticked >= US_W'(cfg.settle_us)) begin
          cmd        = TMR_CLEAR;
          phase_next = PH_TRIG;
        end
      end
      PH_TRIG: begin
        cmd = TMR_TICK;
        if (us_ticked >= US_W'(cfg.trigger_us)) begin
          cmd        = TMR_CLEAR;
          phase_next = PH_RISE;
        end
      end
      PH_RISE: begin
        if (echo_level) begin
          cmd        = TMR_CLEAR;
          phase_next = PH_HIGH;
        end else begin
          cmd = TMR_TICK;
          if (us_ticked > US_W'(cfg.timeout_us)) begin
            done = 1'b1;
            tout = 1'b1;
          end
        end
      end
      PH_HIGH: begin
        if (!echo_level) begin
          done      = 1'b1;
          echo_fell = 1'b1;
        end else begin
          cmd = TMR_TICK;
          if (us_ticked > US_W'(cfg.timeout_us)) begin
            done = 1'b1;
            tout = 1'b1;
          end
        end
      end
      default: begin
        cmd        = TMR_CLEAR;
        phase_next = PH_IDLE;
      end
    endcase
    if (done) begin
      cmd        = TMR_CLEAR;
      phase_next = PH_IDLE;
    end
  end

  // Result values as seen after this tick.
  always_comb begin
    flags.trig = (phase_next == PH_TRIG);
    flags.busy = (phase_next != PH_IDLE);
    flags.done = done;
    flags.tout = done && tout;
    if (tout) begin
      distance_next = '0;
    end else if (echo_fell) begin
      distance_next = echo_cm;
    end else begin
      distance_next = last_distance;
    end
  end

  // Sequencer state moves once per transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      last_distance <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      last_distance <= distance_next;
    end
  end

endmodule

### rtl/ultrasonic_echo_ranger_top.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_top: ultrasonic ranging engine
// Sequences the trigger pulse, times the echo in microseconds and reports
// one result per sampled tick.
//
//   channel  handshake              payload
//   -------  ---------------------  ------------------------------------------
//   in       in_valid / in_ready    start_req, echo_level
//   out      out_valid / out_ready  trig_level, busy_res, done_res,
//                                   distance_cm, timed_out
//   cfg      cfg_wr_en              cfg_index, cfg_data
//
// Every input transfer yields one result in the next cycle, from the result
// register; one item per cycle sustained while out_ready stays high, as the
// sequencer and timer update on each transfer. Synchronous reset puts every
// register but the result payload back to its reset value at once. A stalled
// result holds its register; a new item enters in the cycle the result leaves.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_top
  import uer_pkg::*;
#(
  parameter int DIST_WIDTH = DIST_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  start_req,
  input  logic                  echo_level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  trig_level,
  output logic                  busy_res,
  output logic                  done_res,
  output logic [DIST_WIDTH-1:0] distance_cm,
  output logic                  timed_out
);

  cfg_t                  cfg;
  logic                  accept;
  tmr_cmd_t              cmd;
  logic [US_W-1:0]       us_count;
  logic [US_W-1:0]       us_ticked;
  logic [DIST_WIDTH-1:0] echo_cm;
  res_flags_t            flags;
  logic [DIST_WIDTH-1:0] distance_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cycles_per_us <= CYCLES_PER_US_RST;
      cfg.timeout_us    <= TIMEOUT_US_RST;
      cfg.trigger_us    <= TRIGGER_US_RST;
      cfg.settle_us     <= SETTLE_US_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CYCLES_PER_US: cfg.cycles_per_us <= cfg_data[7:0];
        REG_TIMEOUT_US:    cfg.timeout_us    <= cfg_data;
        REG_TRIGGER_US:    cfg.trigger_us    <= cfg_data[7:0];
        REG_SETTLE_US:     cfg.settle_us     <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  uer_timer u_timer (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .cmd           (cmd),
    .cycles_per_us (cfg.cycles_per_us),
    .us_count      (us_count),
    .us_ticked     (us_ticked)
  );

  uer_dist #(
    .DIST_WIDTH (DIST_WIDTH)
  ) u_dist (
    .us      (us_count),
    .echo_cm (echo_cm)
  );

  uer_ctrl #(
    .DIST_WIDTH (DIST_WIDTH)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .start_req     (start_req),
    .echo_level    (echo_level),
    .cfg           (cfg),
    .us_ticked     (us_ticked),
    .echo_cm       (echo_cm),
    .cmd           (cmd),
    .flags         (flags),
    .distance_next (distance_next)
  );

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload, loaded on each input transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      trig_level  <= flags.trig;
      busy_res    <= flags.busy;
      done_res    <= flags.done;
      distance_cm <= distance_next;
      timed_out   <= flags.tout;
    end
  end

endmodule

### bench/tb_ultrasonic_echo_ranger_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ultrasonic_echo_ranger_top: testbench for the ultrasonic echo ranger
// Sends one sampled tick per input transfer, with random gaps and random
// result stalls. A cycle-level ranging predictor checks every result field.
// Directed tests cover the register extremes and the corner cases of the
// sequencer, then randomized measurements run under several settings.
// ----------------------------------------------------------------------------
module tb_ultrasonic_echo_ranger_top;
  import uer_pkg::*;

  localparam int RANDOM_SENSING = 240;
  localparam int RANDOM_SETTINGS = 8;

  // One result as the block reports it after a tick.
  typedef struct packed {
    logic                      trig;
    logic                      busy;
    logic                      done;
    logic [DIST_WIDTH_DEF-1:0] distance;
    logic                      tout;
  } ranging_result_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_wr_en;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic                      start_req;
  logic                      echo_level;
  logic                      out_valid;
  logic                      out_ready;
  logic                      trig_level;
  logic                      busy_res;
  logic                      done_res;
  logic [DIST_WIDTH_DEF-1:0] distance_cm;
  logic                      timed_out;

  // Predictor state: register copy, sequencer phase and counters.
  cfg_t                      ranger_cfg;
  phase_t                    ranger_phase;
  logic [SUB_W-1:0]          sub_us;
  logic [US_W-1:0]           us_elapsed;
  logic [DIST_WIDTH_DEF-1:0] held_distance;
  logic                      held_timeout;

  ranging_result_t           expected_q[$];
  ranging_result_t           oldest;
  int                        error_count;
  int                        sensing_items;
  bit                        no_idle;

  ultrasonic_echo_ranger_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .start_req   (start_req),
    .echo_level  (echo_level),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .trig_level  (trig_level),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .distance_cm (distance_cm),
    .timed_out   (timed_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("tb: failure");
    $finish;
  end

  // Microsecond prescaler; a reload of zero counts as one.
  function automatic void advance_prescaler();
    logic [SUB_W-1:0] reload;
    reload = (ranger_cfg.cycles_per_us == 8'd0) ? 8'd1 : ranger_cfg.cycles_per_us;
    sub_us = sub_us + 1'b1;
    if (sub_us >= reload) begin
      sub_us = '0;
      if (us_elapsed != US_MAX) us_elapsed = us_elapsed + 1'b1;
    end
  endfunction

  function automatic void clear_timer();
    sub_us = '0;
    us_elapsed = '0;
  endfunction

  // Echo time in microseconds to centimeters, saturated to the output width.
  function automatic logic [DIST_WIDTH_DEF-1:0] us_to_cm(logic [US_W-1:0] us);
    logic [US_W+FACTOR_W-1:0] prod;
    logic [US_W+FACTOR_W-1:0] cm;
    prod = us * DIST_FACTOR;
    cm = prod >> DIST_SHIFT;
    if (cm > {DIST_WIDTH_DEF{1'b1}}) return {DIST_WIDTH_DEF{1'b1}};
    return cm[DIST_WIDTH_DEF-1:0];
  endfunction

  // Advances the predictor by one tick and returns the result it shows.
  function automatic ranging_result_t step_ranger(logic start, logic echo);
    logic            done;
    logic            tout;
    ranging_result_t res;
    done = 1'b0;
    tout = 1'b0;
    if ((ranger_phase == PH_IDLE && start) || ranger_phase == PH_RISE ||
        ranger_phase == PH_HIGH)
      sensing_items++;
    case (ranger_phase)
      PH_IDLE: begin
        if (start) begin
          clear_timer();
          ranger_phase = (ranger_cfg.settle_us == 8'd0) ? PH_TRIG : PH_SETTLE;
        end
      end
      PH_SETTLE: begin
        advance_prescaler();
        if (us_elapsed >= ranger_cfg.settle_us) begin
          clear_timer();
          ranger_phase = PH_TRIG;
        end
      end
      PH_TRIG: begin
        advance_prescaler();
        if (us_elapsed >= ranger_cfg.trigger_us) begin
          clear_timer();
          ranger_phase = PH_RISE;
        end
      end
      PH_RISE: begin
        if (echo) begin
          clear_timer();
          ranger_phase = PH_HIGH;
        end else begin
          advance_prescaler();
          if (us_elapsed > ranger_cfg.timeout_us) begin
            done = 1'b1;
            tout = 1'b1;
          end
        end
      end
      PH_HIGH: begin
        if (!echo) begin
          done = 1'b1;
          held_distance = us_to_cm(us_elapsed);
        end else begin
          advance_prescaler();
          if (us_elapsed > ranger_cfg.timeout_us) begin
            done = 1'b1;
            tout = 1'b1;
          end
        end
      end
      default: begin
        ranger_phase = PH_IDLE;
        clear_timer();
      end
    endcase
    if (done) begin
      if (tout) held_distance = '0;
      held_timeout = tout;
      ranger_phase = PH_IDLE;
      clear_timer();
    end
    res.trig     = (ranger_phase == PH_TRIG);
    res.busy     = (ranger_phase != PH_IDLE);
    res.done     = done;
    res.distance = held_distance;
    res.tout     = done & held_timeout;
    return res;
  endfunction

  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  // Sends one tick after a random gap and predicts its result on transfer.
  task automatic send_item(input logic start, input logic echo);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    start_req  <= start;
    echo_level <= echo;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(step_ranger(start, echo));
  endtask

  // Holds the input side off until every expected result has been seen.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_CYCLES_PER_US: ranger_cfg.cycles_per_us = data[7:0];
      REG_TIMEOUT_US:    ranger_cfg.timeout_us    = data;
      REG_TRIGGER_US:    ranger_cfg.trigger_us    = data[7:0];
      REG_SETTLE_US:     ranger_cfg.settle_us     = data[7:0];
      default: ;
    endcase
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Writes all four registers once the block has gone quiet. The unused upper
  // data bits of the byte registers carry random junk.
  task automatic load_settings(input logic [7:0] cycles, input logic [15:0] tmo,
                               input logic [7:0] trigger, input logic [7:0] settle);
    wait_for_results();
    write_reg(REG_CYCLES_PER_US, {8'($urandom), cycles});
    write_reg(REG_TIMEOUT_US, tmo);
    write_reg(REG_TRIGGER_US, {8'($urandom), trigger});
    write_reg(REG_SETTLE_US, {8'($urandom), settle});
  endtask

  // Start request level while busy: 0 never, 1 always, 2 random.
  function automatic logic busy_start(int mode);
    if (mode == 1) return 1'b1;
    if (mode == 2) return 1'($urandom_range(0, 1));
    return 1'b0;
  endfunction

  // One measurement: start, ride out settle and trigger, hold the echo low for
  // rise_ticks, high for high_ticks, then finish the pulse if still running.
  task automatic measure(input int rise_ticks, input int high_ticks, input int mode);
    int i;
    while (ranger_phase != PH_IDLE)
      send_item(busy_start(mode), 1'($urandom_range(0, 1)));
    send_item(1'b1, 1'($urandom_range(0, 1)));
    while (ranger_phase == PH_SETTLE || ranger_phase == PH_TRIG)
      send_item(busy_start(mode), 1'($urandom_range(0, 1)));
    for (i = 0; i < rise_ticks && ranger_phase == PH_RISE; i++)
      send_item(busy_start(mode), 1'b0);
    for (i = 0; i < high_ticks && ranger_phase != PH_IDLE; i++)
      send_item(busy_start(mode), 1'b1);
    while (ranger_phase != PH_IDLE)
      send_item(busy_start(mode), ranger_phase == PH_RISE);
  endtask

  task automatic send_noise(input int count);
    repeat (count) send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // Reset settings: a short pulse that reads as zero centimeters.
  task automatic test_default_ranging();
    measure(3, 16 * 4 + 3, 2);
  endtask

  // Zero prescaler, timeout, trigger and settle: rise timeout, an echo that
  // is already high on the first sample, and a high-time timeout.
  task automatic test_minimum_settings();
    load_settings(8'd0, 16'd0, 8'd0, 8'd0);
    measure(5, 0, 0);
    measure(0, 0, 0);
    measure(0, 4, 2);
  endtask

  // Start held high through whole measurements, done tick included.
  task automatic test_start_while_busy();
    load_settings(8'd1, 16'd6, 8'd1, 8'd1);
    measure(2, 5, 1);
    measure(10, 0, 1);
  endtask

  // Largest register values, sent back to back.
  task automatic test_extreme_settings();
    load_settings(8'd1, 16'hFFFF, 8'd255, 8'd255);
    no_idle = 1'b1;
    measure(10, 40, 2);
    load_settings(8'd255, 16'hFFFF, 8'd1, 8'd0);
    measure(0, 10, 0);
    no_idle = 1'b0;
  endtask

  // Registers rewritten while the sequencer waits for the echo.
  task automatic test_midrun_write();
    load_settings(8'd2, 16'd1000, 8'd1, 8'd0);
    send_item(1'b1, 1'b0);
    while (ranger_phase != PH_RISE) send_item(1'b0, 1'b0);
    repeat (20) send_item(1'b0, 1'b0);
    wait_for_results();
    write_reg(REG_CYCLES_PER_US, 16'd1);
    write_reg(REG_TIMEOUT_US, 16'd3);
    while (ranger_phase != PH_IDLE) send_item(1'b0, 1'b0);
    send_item(1'b1, 1'b0);
    while (ranger_phase != PH_RISE) send_item(1'b0, 1'b0);
    send_item(1'b0, 1'b1);
    send_item(1'b0, 1'b1);
    wait_for_results();
    write_reg(REG_TIMEOUT_US, 16'd500);
    repeat (5) send_item(1'b0, 1'b1);
    send_item(1'b0, 1'b0);
  endtask

  // Random measurements under several settings, with noise in between.
  task automatic test_random_ranging();
    int p;
    int goal;
    int reload;
    int span;
    for (p = 0; p < RANDOM_SETTINGS; p++) begin
      load_settings(8'($urandom_range(0, 4)),
                    ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 2))
                                                : 16'($urandom_range(3, 40)),
                    8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)));
      no_idle = ($urandom_range(0, 3) == 0);
      goal = sensing_items + RANDOM_SENSING / RANDOM_SETTINGS;
      while (sensing_items < goal) begin
        if ($urandom_range(0, 7) == 0) begin
          send_noise($urandom_range(1, 20));
        end else begin
          reload = (ranger_cfg.cycles_per_us == 8'd0) ? 1 : ranger_cfg.cycles_per_us;
          span = (ranger_cfg.timeout_us + 1) * reload * 3 / 2 + 2;
          measure($urandom_range(0, span), $urandom_range(0, span),
                  $urandom_range(0, 2));
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // Result side: random stall before each transfer.
  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 10);
      repeat (stall) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        note_failure("mismatch: result transfer with nothing expected");
      end else begin
        oldest = expected_q.pop_front();
        if (trig_level !== oldest.trig || busy_res !== oldest.busy ||
            done_res !== oldest.done || distance_cm !== oldest.distance ||
            timed_out !== oldest.tout)
          note_failure($sformatf(
            "mismatch: trig %0b/%0b busy %0b/%0b done %0b/%0b dist %0d/%0d tout %0b/%0b",
            oldest.trig, trig_level, oldest.busy, busy_res, oldest.done, done_res,
            oldest.distance, distance_cm, oldest.tout, timed_out));
      end
    end
  end

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    start_req  <= 1'b0;
    echo_level <= 1'b0;
    cfg_wr_en  <= 1'b0;
    cfg_index  <= REG_CYCLES_PER_US;
    cfg_data   <= '0;
    no_idle = 1'b0;
    error_count = 0;
    sensing_items = 0;
    ranger_cfg.cycles_per_us = CYCLES_PER_US_RST;
    ranger_cfg.timeout_us    = TIMEOUT_US_RST;
    ranger_cfg.trigger_us    = TRIGGER_US_RST;
    ranger_cfg.settle_us     = SETTLE_US_RST;
    ranger_phase  = PH_IDLE;
    sub_us        = '0;
    us_elapsed    = '0;
    held_distance = '0;
    held_timeout  = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_ranging();
    test_minimum_settings();
    test_start_while_busy();
    test_extreme_settings();
    test_midrun_write();
    test_random_ranging();

    wait_for_results();
    repeat (4) @(posedge clk);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
